/* hdl/bmfc_pkg.sv */
package bmfc_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned DB_W        = 8;
  localparam int unsigned SHOT_W      = 3;
  localparam int unsigned ELAPSED_W   = 11;
  localparam int unsigned DELAY_W     = 7;
  localparam int unsigned POT_W       = 10;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  localparam int unsigned CH_TRIG     = 0;
  localparam int unsigned CH_CYC      = 1;
  localparam int unsigned CH_SEL      = 2;

  localparam logic [DB_W-1:0]      DB_MAX      = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [DB_W-1:0]   TRIG_DB_RESET  = 8'd30;
  localparam logic [DB_W-1:0]   CYC_DB_RESET   = 8'd10;
  localparam logic [DB_W-1:0]   SEL_DB_RESET   = 8'd200;
  localparam logic [DB_W-1:0]   TIMEOUT_RESET  = 8'd100;
  localparam logic [SHOT_W-1:0] BURST_RESET    = 3'd3;

  // register indexes
  localparam logic [2:0] REG_TRIG_DB = 3'd0;
  localparam logic [2:0] REG_CYC_DB  = 3'd1;
  localparam logic [2:0] REG_SEL_DB  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_BURST   = 3'd4;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_BURST  = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_t;

  typedef struct packed {
    logic              trigger_level;
    logic              cycle_level;
    logic              selector_level;
    logic [POT_W-1:0]  pot_sample;
  } in_item_t;

  typedef struct packed {
    logic              motor_on;
    logic [1:0]        fire_mode;
    logic [SHOT_W-1:0] shots_pending;
    logic              stop_pending;
  } out_item_t;

  typedef struct packed {
    logic [DB_W-1:0]   trigger_debounce_ms;
    logic [DB_W-1:0]   cycle_debounce_ms;
    logic [DB_W-1:0]   selector_debounce_ms;
    logic [DB_W-1:0]   shot_timeout_ms;
    logic [SHOT_W-1:0] burst_count;
  } cfg_t;

  // 1 + pot*99/1023, division by 1023 done as (x + (x >> 10) + 1) >> 10
  function automatic logic [DELAY_W-1:0] pot_to_delay(input logic [POT_W-1:0] pot);
    logic [16:0] prod;
    logic [16:0] sum;
    prod = {7'd0, pot} * 17'd99;
    sum  = prod + (prod >> 10) + 17'd1;
    return DELAY_W'(sum >> 10) + DELAY_W'(1);
  endfunction

endpackage

/* hdl/bmfc_debounce.sv */
module bmfc_debounce (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [bmfc_pkg::NUM_CH-1:0]            levels,
  input  logic [bmfc_pkg::NUM_CH-1:0][bmfc_pkg::DB_W-1:0] limits,
  output logic [bmfc_pkg::NUM_CH-1:0]            edges
);

  logic [bmfc_pkg::NUM_CH-1:0]                     prev_levels;
  logic [bmfc_pkg::NUM_CH-1:0][bmfc_pkg::DB_W-1:0] elapsed;
  logic [bmfc_pkg::NUM_CH-1:0][bmfc_pkg::DB_W-1:0] elapsed_next;

  always_comb begin
    for (int ch = 0; ch < bmfc_pkg::NUM_CH; ch++) begin
      if (elapsed[ch] != bmfc_pkg::DB_MAX) begin
        elapsed_next[ch] = elapsed[ch] + bmfc_pkg::DB_W'(1);
      end else begin
        elapsed_next[ch] = elapsed[ch];
      end
      edges[ch] = levels[ch] && !prev_levels[ch] && (elapsed_next[ch] > limits[ch]);
      if (edges[ch]) begin
        elapsed_next[ch] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      for (int ch = 0; ch < bmfc_pkg::NUM_CH; ch++) begin
        elapsed[ch] <= bmfc_pkg::DB_MAX;
      end
    end else if (accept) begin
      prev_levels <= levels;
      elapsed     <= elapsed_next;
    end
  end

endmodule

/* hdl/bmfc_core.sv */
module bmfc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [bmfc_pkg::NUM_CH-1:0]   edges,
  input  logic                          trig_held,
  input  logic [bmfc_pkg::POT_W-1:0]    pot,
  input  bmfc_pkg::cfg_t                cfg,
  output bmfc_pkg::out_item_t           result
);

  bmfc_pkg::mode_t                   mode;
  bmfc_pkg::mode_t                   mode_next;
  logic [bmfc_pkg::SHOT_W-1:0]       shots;
  logic [bmfc_pkg::SHOT_W-1:0]       shots_next;
  logic                              running;
  logic                              running_next;
  logic [bmfc_pkg::ELAPSED_W-1:0]    run_elapsed;
  logic [bmfc_pkg::ELAPSED_W-1:0]    run_elapsed_next;
  logic [bmfc_pkg::NUM_CH-1:0]       pending;
  logic [bmfc_pkg::NUM_CH-1:0]       pending_next;
  logic [bmfc_pkg::DELAY_W-1:0]      countdown;
  logic [bmfc_pkg::DELAY_W-1:0]      countdown_next;
  logic [bmfc_pkg::DELAY_W-1:0]      stop_delay;
  logic [bmfc_pkg::ELAPSED_W-1:0]    limit;
  logic                              done;

  assign stop_delay = bmfc_pkg::pot_to_delay(pot);

  always_comb begin
    mode_next        = mode;
    shots_next       = shots;
    running_next     = running;
    run_elapsed_next = run_elapsed;
    pending_next     = pending | edges;
    countdown_next   = countdown;
    done             = 1'b0;
    limit            = '0;

    if (running && run_elapsed != bmfc_pkg::ELAPSED_MAX) begin
      run_elapsed_next = run_elapsed + bmfc_pkg::ELAPSED_W'(1);
    end

    if (countdown != '0) begin
      if (mode == bmfc_pkg::MODE_AUTO && trig_held) begin
        countdown_next = '0;
      end else begin
        countdown_next = countdown - bmfc_pkg::DELAY_W'(1);
        if (countdown_next == '0) begin
          running_next = 1'b0;
          shots_next   = '0;
        end
      end
    end else begin
      // trigger
      if (pending_next[bmfc_pkg::CH_TRIG]) begin
        pending_next[bmfc_pkg::CH_TRIG] = 1'b0;
        if (!running) begin
          if (mode == bmfc_pkg::MODE_SINGLE && shots == '0) begin
            shots_next       = bmfc_pkg::SHOT_W'(1);
            running_next     = 1'b1;
            run_elapsed_next = '0;
          end else if (mode == bmfc_pkg::MODE_BURST && shots == '0) begin
            shots_next       = cfg.burst_count;
            running_next     = 1'b1;
            run_elapsed_next = '0;
          end else if (mode == bmfc_pkg::MODE_AUTO) begin
            shots_next       = bmfc_pkg::SHOT_W'(1);
            running_next     = 1'b1;
            run_elapsed_next = '0;
          end
        end
      end

      // cycle sensor
      if (pending_next[bmfc_pkg::CH_CYC]) begin
        pending_next[bmfc_pkg::CH_CYC] = 1'b0;
        if (running_next) begin
          if (mode == bmfc_pkg::MODE_AUTO && trig_held) begin
            shots_next = bmfc_pkg::SHOT_W'(1);
          end else if (shots_next != '0) begin
            shots_next = shots_next - bmfc_pkg::SHOT_W'(1);
          end
          if (shots_next == '0) begin
            countdown_next = stop_delay;
            done           = 1'b1;
          end
        end
      end

      if (!done) begin
        if (pending_next[bmfc_pkg::CH_SEL]) begin
          pending_next[bmfc_pkg::CH_SEL] = 1'b0;
          case (mode)
            bmfc_pkg::MODE_SINGLE: mode_next = bmfc_pkg::MODE_BURST;
            bmfc_pkg::MODE_BURST:  mode_next = bmfc_pkg::MODE_AUTO;
            default:               mode_next = bmfc_pkg::MODE_SINGLE;
          endcase
        end

        // full auto release
        if (mode_next == bmfc_pkg::MODE_AUTO && !trig_held && running_next
            && shots_next != '0) begin
          running_next = 1'b0;
          shots_next   = '0;
        end

        // safety timeout
        limit = bmfc_pkg::ELAPSED_W'(cfg.shot_timeout_ms) * bmfc_pkg::ELAPSED_W'(shots_next);
        if (running_next && mode_next != bmfc_pkg::MODE_AUTO && run_elapsed_next >= limit) begin
          running_next = 1'b0;
          shots_next   = '0;
        end
      end
    end

    result.motor_on      = running_next;
    result.fire_mode     = mode_next;
    result.shots_pending = shots_next;
    result.stop_pending  = (countdown_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bmfc_pkg::MODE_SINGLE;
      shots       <= '0;
      running     <= 1'b0;
      run_elapsed <= '0;
      pending     <= '0;
      countdown   <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      shots       <= shots_next;
      running     <= running_next;
      run_elapsed <= run_elapsed_next;
      pending     <= pending_next;
      countdown   <= countdown_next;
    end
  end

endmodule

/* hdl/bmfc_outq.sv */
module bmfc_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bmfc_pkg::out_item_t  push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmfc_pkg::out_item_t  out_data
);

  bmfc_pkg::out_item_t entry0;
  bmfc_pkg::out_item_t entry1;
  logic                head;
  logic [1:0]          count;
  logic                tail;
  logic                pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = head ? entry1 : entry0;
  assign pop       = out_valid && !out_stall;
  assign tail      = head ^ count[0];

  always_ff @(posedge clk) begin
    if (push) begin
      if (tail) begin
        entry1 <= push_data;
      end else begin
        entry0 <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= !head;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/burst_motor_fire_controller_top.sv */
// output: a result is registered in the output queue when its tick item is accepted
// throughput: one item per cycle while the queue is not full; the state update is a
// single pass per item and a two-entry output queue lets input continue while a result waits
// reset: synchronous, clears mode, shot count, motor, counters and the queue;
// debounce timers start saturated and the registers take their default values
module burst_motor_fire_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bmfc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bmfc_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmfc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bmfc_pkg::DATA_W-1:0]    pwdata,
  output logic [bmfc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  bmfc_pkg::cfg_t                                   cfg;
  logic                                             accept;
  logic                                             q_full;
  logic [bmfc_pkg::NUM_CH-1:0]                      levels;
  logic [bmfc_pkg::NUM_CH-1:0][bmfc_pkg::DB_W-1:0]  limits;
  logic [bmfc_pkg::NUM_CH-1:0]                      edges;
  bmfc_pkg::out_item_t                              result;
  logic [2:0]                                       reg_idx;
  logic                                             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_debounce_ms  <= bmfc_pkg::TRIG_DB_RESET;
      cfg.cycle_debounce_ms    <= bmfc_pkg::CYC_DB_RESET;
      cfg.selector_debounce_ms <= bmfc_pkg::SEL_DB_RESET;
      cfg.shot_timeout_ms      <= bmfc_pkg::TIMEOUT_RESET;
      cfg.burst_count          <= bmfc_pkg::BURST_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        bmfc_pkg::REG_TRIG_DB: cfg.trigger_debounce_ms  <= pwdata[7:0];
        bmfc_pkg::REG_CYC_DB:  cfg.cycle_debounce_ms    <= pwdata[7:0];
        bmfc_pkg::REG_SEL_DB:  cfg.selector_debounce_ms <= pwdata[7:0];
        bmfc_pkg::REG_TIMEOUT: cfg.shot_timeout_ms      <= pwdata[7:0];
        bmfc_pkg::REG_BURST:   cfg.burst_count          <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bmfc_pkg::REG_TRIG_DB: prdata = bmfc_pkg::DATA_W'(cfg.trigger_debounce_ms);
      bmfc_pkg::REG_CYC_DB:  prdata = bmfc_pkg::DATA_W'(cfg.cycle_debounce_ms);
      bmfc_pkg::REG_SEL_DB:  prdata = bmfc_pkg::DATA_W'(cfg.selector_debounce_ms);
      bmfc_pkg::REG_TIMEOUT: prdata = bmfc_pkg::DATA_W'(cfg.shot_timeout_ms);
      bmfc_pkg::REG_BURST:   prdata = bmfc_pkg::DATA_W'(cfg.burst_count);
      default:               prdata = '0;
    endcase
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign levels[bmfc_pkg::CH_TRIG] = in_data.trigger_level;
  assign levels[bmfc_pkg::CH_CYC]  = in_data.cycle_level;
  assign levels[bmfc_pkg::CH_SEL]  = in_data.selector_level;

  assign limits[bmfc_pkg::CH_TRIG] = cfg.trigger_debounce_ms;
  assign limits[bmfc_pkg::CH_CYC]  = cfg.cycle_debounce_ms;
  assign limits[bmfc_pkg::CH_SEL]  = cfg.selector_debounce_ms;

  bmfc_debounce u_debounce (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .levels (levels),
    .limits (limits),
    .edges  (edges)
  );

  bmfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .edges     (edges),
    .trig_held (in_data.trigger_level),
    .pot       (in_data.pot_sample),
    .cfg       (cfg),
    .result    (result)
  );

  bmfc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stop_pending) |-> out_data.motor_on)
    else $error("stop countdown with motor off");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.motor_on) |-> (out_data.shots_pending == '0))
    else $error("shots pending with motor off");

  assert property (@(posedge clk) (!rst && $past(rst)) |-> !out_valid)
    else $error("result offered right after reset");

endmodule
